@@ sv/prae_pkg.sv @@
// ----------------------------------------------------------------------------
// prae_pkg
// Shared widths, constants and types of the position report encoder.
// ----------------------------------------------------------------------------
package prae_pkg;

    localparam int LatW   = 28;
    localparam int LonW   = 29;
    localparam int CoordW = 29;
    localparam int FixW   = 3;
    localparam int CharW  = 8;
    localparam int DigW   = 4;
    localparam int AddrW  = 3;
    localparam int DataW  = 32;

    localparam int NStages = 10;
    localparam int RptLen  = 20;
    localparam int CntW    = 5;

    // reciprocal of 15625 (1e6 / 64), exact for quotients below 2^22
    localparam logic [22:0] RecipMillion = 23'd4398047;
    localparam int          RecipShift1  = 36;
    // reciprocal of 625 (1e4 / 16), exact for quotients below 2^16
    localparam logic [16:0] RecipTenK    = 17'd107375;
    localparam int          RecipShift3  = 26;

    localparam logic [19:0] Million   = 20'd1000000;
    localparam logic [19:0] HalfHund  = 20'd5000;

    localparam logic [CharW-1:0] AsciiBang  = 8'h21;
    localparam logic [CharW-1:0] AsciiZero  = 8'h30;
    localparam logic [CharW-1:0] AsciiDot   = 8'h2e;
    localparam logic [CharW-1:0] AsciiN     = 8'h4e;
    localparam logic [CharW-1:0] AsciiS     = 8'h53;
    localparam logic [CharW-1:0] AsciiE     = 8'h45;
    localparam logic [CharW-1:0] AsciiW     = 8'h57;
    localparam logic [CharW-1:0] AsciiNul   = 8'h00;

    localparam logic RegSymTable = 1'b0;
    localparam logic RegSymCode  = 1'b1;
    localparam int   RegSelBit   = 2;

    localparam logic [CharW-1:0] SymTableRst = 8'd47;
    localparam logic [CharW-1:0] SymCodeRst  = 8'd62;

    typedef struct packed {
        logic            neg;
        logic [DigW-1:0] deg_h;
        logic [DigW-1:0] deg_t;
        logic [DigW-1:0] deg_o;
        logic [DigW-1:0] min_t;
        logic [DigW-1:0] min_o;
        logic [DigW-1:0] hun_t;
        logic [DigW-1:0] hun_o;
    } prae_digits_t;

endpackage

@@ sv/prae_pos_if.sv @@
// ----------------------------------------------------------------------------
// prae_pos_if
// Position request channel: latitude, longitude and fix quality.
// ----------------------------------------------------------------------------
interface prae_pos_if
    import prae_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic signed [LatW-1:0] lat_micro;
    logic signed [LonW-1:0] lon_micro;
    logic [FixW-1:0]        fix_level;

    modport source (output valid, lat_micro, lon_micro, fix_level, input ready);
    modport sink   (input valid, lat_micro, lon_micro, fix_level, output ready);
endinterface

@@ sv/prae_rpt_if.sv @@
// ----------------------------------------------------------------------------
// prae_rpt_if
// Report byte channel: one ASCII byte per request with end and invalid flags.
// ----------------------------------------------------------------------------
interface prae_rpt_if
    import prae_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CharW-1:0] out_char;
    logic             last_char;
    logic             pos_invalid;

    modport source (output valid, out_char, last_char, pos_invalid, input ready);
    modport sink   (input valid, out_char, last_char, pos_invalid, output ready);
endinterface

@@ sv/prae_coord.sv @@
// ----------------------------------------------------------------------------
// prae_coord
// Ten-stage pipeline turning signed microdegrees into degree, minute and
// hundredth digits plus the hemisphere sign.
// ----------------------------------------------------------------------------
module prae_coord
    import prae_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [CoordW-1:0] value,
    output prae_digits_t             digits
);

    localparam int DegW  = 9;
    localparam int FracW = 20;
    localparam int ScW   = 26;
    localparam int MinW  = 6;
    localparam int RemW  = 20;
    localparam int HW    = 3;
    localparam int RdW   = 7;
    localparam int HunW  = 7;
    localparam int P1W   = 46;
    localparam int P2W   = 43;
    localparam int P3W   = 33;
    localparam int MulW  = 15;

    // stage 1
    logic [CoordW-1:0] mag1_reg, mag1_next;
    logic              neg1_reg;
    // stage 2
    logic [P1W-1:0]    p1_reg, p1_next;
    logic [CoordW-1:0] mag2_reg;
    logic              neg2_reg;
    // stage 3
    logic [DegW-1:0]   deg3_reg, deg3_next;
    logic [FracW-1:0]  frac3_reg, frac3_next;
    logic              neg3_reg;
    // stage 4
    logic [DegW-1:0]   deg4_reg;
    logic [HW-1:0]     h4_reg, h4_next;
    logic [ScW-1:0]    sc4_reg, sc4_next;
    logic              neg4_reg;
    // stage 5
    logic [HW-1:0]     h5_reg;
    logic [RdW-1:0]    rd5_reg, rd5_next;
    logic [P2W-1:0]    p2_reg, p2_next;
    logic [ScW-1:0]    sc5_reg;
    logic              neg5_reg;
    // stage 6
    logic [HW-1:0]     h6_reg;
    logic [RdW-1:0]    rd6_reg;
    logic [DigW-1:0]   dt6_reg, dt6_next;
    logic [MinW-1:0]   min6_reg, min6_next;
    logic [RemW-1:0]   rem6_reg, rem6_next;
    logic              neg6_reg;
    // stage 7
    logic [HW-1:0]     h7_reg;
    logic [DigW-1:0]   dt7_reg;
    logic [DigW-1:0]   do7_reg, do7_next;
    logic [MinW-1:0]   min7_reg;
    logic [DigW-1:0]   mt7_reg, mt7_next;
    logic [P3W-1:0]    p3_reg, p3_next;
    logic              neg7_reg;
    // stage 8
    logic [HW-1:0]     h8_reg;
    logic [DigW-1:0]   dt8_reg, do8_reg, mt8_reg;
    logic [DigW-1:0]   mo8_reg, mo8_next;
    logic [HunW-1:0]   hund8_reg, hund8_next;
    logic              neg8_reg;
    // stage 9
    logic [HW-1:0]     h9_reg;
    logic [DigW-1:0]   dt9_reg, do9_reg, mt9_reg, mo9_reg;
    logic [HunW-1:0]   hund9_reg;
    logic [DigW-1:0]   ht9_reg, ht9_next;
    logic              neg9_reg;
    // stage 10
    prae_digits_t      dig_reg, dig_next;

    logic [RemW-1:0]   rnd_sum;
    logic [HunW-1:0]   hund_raw;

    always_comb
    begin
        mag1_next  = value[CoordW-1] ? unsigned'(-value) : unsigned'(value);

        p1_next    = P1W'(mag1_reg[CoordW-1:6]) * P1W'(RecipMillion);

        deg3_next  = p1_reg[RecipShift1 +: DegW];
        frac3_next = FracW'(mag2_reg - CoordW'(deg3_next) * CoordW'(Million));

        sc4_next   = ScW'(frac3_reg) * ScW'(6'd60);
        h4_next    = HW'((MulW'(deg3_reg) * MulW'(41)) >> 12);

        p2_next    = P2W'(sc4_reg[ScW-1:6]) * P2W'(RecipMillion);
        rd5_next   = RdW'(deg4_reg - DegW'(h4_reg) * DegW'(100));

        min6_next  = p2_reg[RecipShift1 +: MinW];
        rem6_next  = RemW'(sc5_reg - ScW'(min6_next) * ScW'(Million));
        dt6_next   = DigW'((MulW'(rd5_reg) * MulW'(205)) >> 11);

        rnd_sum    = rem6_reg + HalfHund;
        p3_next    = P3W'(rnd_sum[RemW-1:4]) * P3W'(RecipTenK);
        do7_next   = DigW'(rd6_reg - RdW'(dt6_reg) * RdW'(10));
        mt7_next   = DigW'((MulW'(min6_reg) * MulW'(205)) >> 11);

        hund_raw   = p3_reg[RecipShift3 +: HunW];
        hund8_next = (hund_raw == HunW'(100)) ? '0 : hund_raw;
        mo8_next   = DigW'(min7_reg - MinW'(mt7_reg) * MinW'(10));

        ht9_next   = DigW'((MulW'(hund8_reg) * MulW'(205)) >> 11);

        dig_next.neg   = neg9_reg;
        dig_next.deg_h = DigW'(h9_reg);
        dig_next.deg_t = dt9_reg;
        dig_next.deg_o = do9_reg;
        dig_next.min_t = mt9_reg;
        dig_next.min_o = mo9_reg;
        dig_next.hun_t = ht9_reg;
        dig_next.hun_o = DigW'(hund9_reg - HunW'(ht9_reg) * HunW'(10));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg  <= mag1_next;
            neg1_reg  <= value[CoordW-1];

            p1_reg    <= p1_next;
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;

            deg3_reg  <= deg3_next;
            frac3_reg <= frac3_next;
            neg3_reg  <= neg2_reg;

            deg4_reg  <= deg3_reg;
            h4_reg    <= h4_next;
            sc4_reg   <= sc4_next;
            neg4_reg  <= neg3_reg;

            h5_reg    <= h4_reg;
            rd5_reg   <= rd5_next;
            p2_reg    <= p2_next;
            sc5_reg   <= sc4_reg;
            neg5_reg  <= neg4_reg;

            h6_reg    <= h5_reg;
            rd6_reg   <= rd5_reg;
            dt6_reg   <= dt6_next;
            min6_reg  <= min6_next;
            rem6_reg  <= rem6_next;
            neg6_reg  <= neg5_reg;

            h7_reg    <= h6_reg;
            dt7_reg   <= dt6_reg;
            do7_reg   <= do7_next;
            min7_reg  <= min6_reg;
            mt7_reg   <= mt7_next;
            p3_reg    <= p3_next;
            neg7_reg  <= neg6_reg;

            h8_reg    <= h7_reg;
            dt8_reg   <= dt7_reg;
            do8_reg   <= do7_reg;
            mt8_reg   <= mt7_reg;
            mo8_reg   <= mo8_next;
            hund8_reg <= hund8_next;
            neg8_reg  <= neg7_reg;

            h9_reg    <= h8_reg;
            dt9_reg   <= dt8_reg;
            do9_reg   <= do8_reg;
            mt9_reg   <= mt8_reg;
            mo9_reg   <= mo8_reg;
            hund9_reg <= hund8_reg;
            ht9_reg   <= ht9_next;
            neg9_reg  <= neg8_reg;

            dig_reg   <= dig_next;
        end
    end

    assign digits = dig_reg;

endmodule

@@ sv/position_report_ascii_encoder.sv @@
// ----------------------------------------------------------------------------
// position_report_ascii_encoder
// Encodes a position as an uncompressed ASCII position report, byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   pos  : one request per position (lat_micro, lon_micro, fix_level),
//          accepted on valid && ready.
//   rpt  : one request per report byte; last_char marks the final byte.
//          A valid position gives 20 bytes; no fix or a zero position
//          gives one NUL byte with pos_invalid and last_char set.
//   APB  : symbol_table at 0x0, symbol_code at 0x4; write only while idle.
// Timing:
//   The position passes a 10-stage digit pipeline, then loads a 20-byte
//   output shifter. Throughput is one byte per cycle while rpt is ready;
//   the next report loads as the last byte of the one before is taken.
// Reset:
//   Clears all valid bits and loads the symbol registers with '/' and '>'.
// Stall:
//   When rpt is not ready the pipeline keeps filling until its last stage
//   holds a position the shifter cannot take, then stalls with pos.ready low.
// ----------------------------------------------------------------------------
module position_report_ascii_encoder
    import prae_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    prae_pos_if.sink          pos,
    prae_rpt_if.source        rpt,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AddrW-1:0]  paddr,
    input  logic [DataW-1:0]  pwdata,
    output logic [DataW-1:0]  prdata,
    output logic              pready
);

    logic [CharW-1:0]   sym_table_reg;
    logic [CharW-1:0]   sym_code_reg;
    logic               cfg_wr;

    logic [NStages-1:0] vld_reg, vld_next;
    logic [NStages-1:0] inv_reg, inv_next;
    logic               adv;
    logic               pos_inv;

    prae_digits_t       lat_dig;
    prae_digits_t       lon_dig;

    logic [CharW-1:0]   txt_reg  [RptLen];
    logic [CharW-1:0]   txt_next [RptLen];
    logic [CharW-1:0]   rpt_bytes[RptLen];
    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic               ser_vld_reg, ser_vld_next;
    logic               ser_inv_reg, ser_inv_next;
    logic               ser_take;
    logic               ser_load;
    logic               rpt_acc;

    function automatic logic [CharW-1:0] to_ascii(input logic [DigW-1:0] d);
        to_ascii = AsciiZero | CharW'(d);
    endfunction

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_table_reg <= SymTableRst;
            sym_code_reg  <= SymCodeRst;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[RegSelBit])
                RegSymTable: sym_table_reg <= pwdata[CharW-1:0];
                RegSymCode:  sym_code_reg  <= pwdata[CharW-1:0];
                default:     sym_table_reg <= sym_table_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[RegSelBit])
            RegSymTable: prdata = DataW'(sym_table_reg);
            RegSymCode:  prdata = DataW'(sym_code_reg);
            default:     prdata = '0;
        endcase
    end

    assign ser_take = !ser_vld_reg || (rpt.ready && cnt_reg == CntW'(1));
    assign adv      = !vld_reg[NStages-1] || ser_take;
    assign ser_load = vld_reg[NStages-1] && ser_take;
    assign rpt_acc  = rpt.valid && rpt.ready;

    assign pos.ready = adv;
    assign pos_inv   = (pos.fix_level == '0)
                       || (pos.lat_micro == '0 && pos.lon_micro == '0);

    always_comb
    begin
        vld_next = {vld_reg[NStages-2:0], pos.valid && pos.ready};
        inv_next = {inv_reg[NStages-2:0], pos_inv};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            inv_reg <= inv_next;
        end
    end

    prae_coord u_lat (
        .clk    (clk),
        .en     (adv),
        .value  (CoordW'(pos.lat_micro)),
        .digits (lat_dig)
    );

    prae_coord u_lon (
        .clk    (clk),
        .en     (adv),
        .value  (CoordW'(pos.lon_micro)),
        .digits (lon_dig)
    );

    always_comb
    begin
        rpt_bytes[0]  = AsciiBang;
        rpt_bytes[1]  = to_ascii(lat_dig.deg_t);
        rpt_bytes[2]  = to_ascii(lat_dig.deg_o);
        rpt_bytes[3]  = to_ascii(lat_dig.min_t);
        rpt_bytes[4]  = to_ascii(lat_dig.min_o);
        rpt_bytes[5]  = AsciiDot;
        rpt_bytes[6]  = to_ascii(lat_dig.hun_t);
        rpt_bytes[7]  = to_ascii(lat_dig.hun_o);
        rpt_bytes[8]  = lat_dig.neg ? AsciiS : AsciiN;
        rpt_bytes[9]  = sym_table_reg;
        rpt_bytes[10] = to_ascii(lon_dig.deg_h);
        rpt_bytes[11] = to_ascii(lon_dig.deg_t);
        rpt_bytes[12] = to_ascii(lon_dig.deg_o);
        rpt_bytes[13] = to_ascii(lon_dig.min_t);
        rpt_bytes[14] = to_ascii(lon_dig.min_o);
        rpt_bytes[15] = AsciiDot;
        rpt_bytes[16] = to_ascii(lon_dig.hun_t);
        rpt_bytes[17] = to_ascii(lon_dig.hun_o);
        rpt_bytes[18] = lon_dig.neg ? AsciiW : AsciiE;
        rpt_bytes[19] = sym_code_reg;
        if (inv_reg[NStages-1])
        begin
            rpt_bytes[0] = AsciiNul;
        end
    end

    always_comb
    begin
        txt_next     = txt_reg;
        cnt_next     = cnt_reg;
        ser_vld_next = ser_vld_reg;
        ser_inv_next = ser_inv_reg;
        priority if (ser_load)
        begin
            txt_next     = rpt_bytes;
            cnt_next     = inv_reg[NStages-1] ? CntW'(1) : CntW'(RptLen);
            ser_vld_next = 1'b1;
            ser_inv_next = inv_reg[NStages-1];
        end
        else if (rpt_acc)
        begin
            for (int i = 0; i < RptLen - 1; i++)
            begin
                txt_next[i] = txt_reg[i+1];
            end
            txt_next[RptLen-1] = AsciiNul;
            cnt_next           = cnt_reg - CntW'(1);
            ser_vld_next       = (cnt_reg != CntW'(1));
        end
        else
        begin
            ser_vld_next = ser_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_vld_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            ser_vld_reg <= ser_vld_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        txt_reg     <= txt_next;
        ser_inv_reg <= ser_inv_next;
    end

    assign rpt.valid       = ser_vld_reg;
    assign rpt.out_char    = txt_reg[0];
    assign rpt.last_char   = (cnt_reg == CntW'(1));
    assign rpt.pos_invalid = ser_inv_reg;

endmodule

@@ sim/position_report_ascii_encoder_tb.sv @@
// ----------------------------------------------------------------------------
// position_report_ascii_encoder_tb
// Drives positions into the encoder and checks every report byte against an
// integer model of the report text. Covers field extremes, minute rounding,
// hemisphere letters, invalid positions, symbol register settings, random
// traffic with bursty input and a stalling output, and long output hold-offs.
// ----------------------------------------------------------------------------
module position_report_ascii_encoder_tb;
    import prae_pkg::*;

    typedef struct packed {
        logic [CharW-1:0] ch;
        logic             last;
        logic             invalid;
    } rpt_byte_t;

    typedef enum int {RxAlways, RxRandom, RxPeriodic} rx_mode_e;

    localparam longint MicroPerDeg   = 1000000;
    localparam longint MinPerDeg     = 60;
    localparam longint HalfHundredth = 5000;
    localparam longint Hundredth     = 10000;
    localparam longint LatSpan       = 90000000;
    localparam longint LonSpan       = 180000000;
    localparam int     DrainCycles   = 24;
    localparam int     MaxPrinted    = 40;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    prae_pos_if pos_ch ();
    prae_rpt_if rpt_ch ();

    position_report_ascii_encoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pos     (pos_ch),
        .rpt     (rpt_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rpt_byte_t        pending_bytes[$];
    rpt_byte_t        want_byte;
    logic [CharW-1:0] sym_table;
    logic [CharW-1:0] sym_code;
    int               mismatch_count = 0;
    int               bytes_seen = 0;
    int               tx_gap_max = 0;
    int               tx_burst_left = 0;
    rx_mode_e         rx_mode = RxAlways;
    int               rx_stall_pct = 0;
    int               rx_hold_len = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        if (mismatch_count <= MaxPrinted)
            $display("mismatch at byte %0d: %s got %0h expected %0h",
                     bytes_seen, what, got, want);
    endtask

    function automatic logic [CharW-1:0] digit_char(longint d);
        return AsciiZero + CharW'(d);
    endfunction

    function automatic void push_char(logic [CharW-1:0] c, logic last);
        pending_bytes.insert(pending_bytes.size(), '{ch: c, last: last, invalid: 1'b0});
    endfunction

    function automatic void push_coord(longint value, bit three_deg,
                                       logic [CharW-1:0] pos_c,
                                       logic [CharW-1:0] neg_c);
        longint mag;
        longint deg;
        longint scaled;
        longint mins;
        longint hund;
        mag = (value < 0) ? -value : value;
        deg = mag / MicroPerDeg;
        scaled = (mag % MicroPerDeg) * MinPerDeg;
        mins = scaled / MicroPerDeg;
        hund = (((scaled % MicroPerDeg) + HalfHundredth) / Hundredth) % 100;
        if (three_deg)
            push_char(digit_char((deg / 100) % 10), 1'b0);
        push_char(digit_char((deg / 10) % 10), 1'b0);
        push_char(digit_char(deg % 10), 1'b0);
        push_char(digit_char(mins / 10), 1'b0);
        push_char(digit_char(mins % 10), 1'b0);
        push_char(AsciiDot, 1'b0);
        push_char(digit_char(hund / 10), 1'b0);
        push_char(digit_char(hund % 10), 1'b0);
        push_char((value >= 0) ? pos_c : neg_c, 1'b0);
    endfunction

    function automatic void predict_report(longint lat, longint lon, logic [FixW-1:0] fix);
        if (fix == 0 || (lat == 0 && lon == 0))
        begin
            pending_bytes.insert(pending_bytes.size(),
                                 '{ch: AsciiNul, last: 1'b1, invalid: 1'b1});
            return;
        end
        push_char(AsciiBang, 1'b0);
        push_coord(lat, 1'b0, AsciiN, AsciiS);
        push_char(sym_table, 1'b0);
        push_coord(lon, 1'b1, AsciiE, AsciiW);
        push_char(sym_code, 1'b1);
    endfunction

    function automatic longint gen_coord(longint span, int width);
        longint v;
        longint edges[6];
        edges = '{0, 999999, 999917, 16750, 16749, 500000};
        case ($urandom_range(9))
            0, 1, 2, 3: v = longint'($urandom_range(0, 2 * span)) - span;
            4, 5:
            begin
                v = longint'($urandom()) & ((64'sd1 <<< width) - 1);
                if (v >= (64'sd1 <<< (width - 1)))
                    v = v - (64'sd1 <<< width);
            end
            6: v = longint'($urandom_range(0, 4000000)) - 2000000;
            7:
            begin
                v = longint'($urandom_range(0, span / MicroPerDeg)) * MicroPerDeg
                    + edges[$urandom_range(5)];
                if ($urandom_range(1))
                    v = -v;
            end
            8: v = 0;
            default: v = longint'($urandom_range(0, 2 * span)) - span;
        endcase
        return v;
    endfunction

    task automatic send_pos(longint lat, longint lon, int fix);
        logic signed [LatW-1:0] lat_v;
        logic signed [LonW-1:0] lon_v;
        logic [FixW-1:0]        fix_v;
        lat_v = lat[LatW-1:0];
        lon_v = lon[LonW-1:0];
        fix_v = FixW'(fix);
        pos_ch.valid     <= 1'b1;
        pos_ch.lat_micro <= lat_v;
        pos_ch.lon_micro <= lon_v;
        pos_ch.fix_level <= fix_v;
        @(posedge clk);
        while (!pos_ch.ready)
            @(posedge clk);
        predict_report(longint'(lat_v), longint'(lon_v), fix_v);
        if (tx_gap_max != 0)
        begin
            if (tx_burst_left != 0)
                tx_burst_left--;
            if (tx_burst_left == 0)
            begin
                pos_ch.valid <= 1'b0;
                repeat ($urandom_range(1, tx_gap_max))
                    @(posedge clk);
                tx_burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic send_random(bit valid_only);
        send_pos(gen_coord(LatSpan, LatW), gen_coord(LonSpan, LonW),
                 valid_only ? $urandom_range(1, 7) : $urandom_range(7));
    endtask

    task automatic wait_idle();
        pos_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DrainCycles)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic idx, logic [CharW-1:0] value);
        logic [DataW-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(idx) << RegSelBit;
        pwdata  <= DataW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd != DataW'(value))
            report_mismatch("register readback", rd, value);
    endtask

    task automatic set_symbols(logic [CharW-1:0] table_v, logic [CharW-1:0] code_v);
        wait_idle();
        cfg_write(RegSymTable, table_v);
        sym_table = table_v;
        cfg_write(RegSymCode, code_v);
        sym_code = code_v;
        @(posedge clk);
    endtask

    task automatic test_reset_symbols();
        rx_mode = RxAlways;
        tx_gap_max = 0;
        send_pos(37422000, -122084000, 1);
        send_pos(-33868800, 151209300, 3);
        send_pos(51500000, -125000, 2);
        wait_idle();
    endtask

    task automatic test_field_extremes();
        rx_mode = RxRandom;
        rx_stall_pct = 30;
        tx_gap_max = 6;
        send_pos(0, 0, 1);
        send_pos(12345678, 0, 0);
        send_pos(LatSpan, LonSpan, 7);
        send_pos(-LatSpan, -LonSpan, 1);
        send_pos((64'sd1 <<< (LatW - 1)) - 1, (64'sd1 <<< (LonW - 1)) - 1, 3);
        send_pos(-(64'sd1 <<< (LatW - 1)), -(64'sd1 <<< (LonW - 1)), 4);
        send_pos(0, 123456789, 2);
        send_pos(-45500000, 0, 5);
        send_pos(16750, 16749, 1);
        send_pos(999917, -179999917, 6);
        send_pos(99999999, 100000000, 1);
        send_pos(100000000, 199000000, 1);
        send_pos(1, -1, 1);
        send_pos(-1, 1, 1);
        send_pos(0, 0, 0);
        send_pos(LatSpan, 0, 0);
        send_pos(59999999, 9999999, 7);
        send_pos(33333333, -66666666, 2);
        send_pos(500000, -500000, 1);
        wait_idle();
    endtask

    task automatic test_symbol_settings();
        rx_mode = RxPeriodic;
        tx_gap_max = 4;
        set_symbols(8'h00, 8'hff);
        repeat (8)
            send_random(1'b0);
        set_symbols(8'hff, 8'h00);
        repeat (8)
            send_random(1'b0);
        set_symbols(8'h5c, 8'h2d);
        repeat (8)
            send_random(1'b0);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        rx_mode = RxAlways;
        tx_gap_max = 0;
        rx_hold_len = 400;
        repeat (30)
            send_random(1'b1);
        rx_mode = RxRandom;
        rx_stall_pct = 50;
        rx_hold_len = 150;
        repeat (10)
            send_random(1'b0);
        wait_idle();
    endtask

    task automatic test_pause_until_empty();
        rx_mode = RxRandom;
        rx_stall_pct = 20;
        tx_gap_max = 10;
        repeat (10)
            send_random(1'b0);
        pos_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        @(posedge clk);
        repeat (10)
            send_random(1'b0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++)
        begin
            set_symbols(CharW'($urandom_range(255)), CharW'($urandom_range(255)));
            rx_mode = rx_mode_e'(ph % 3);
            rx_stall_pct = $urandom_range(10, 70);
            tx_gap_max = (ph == 0) ? 0 : $urandom_range(2, 20);
            repeat (85)
                send_random(1'b0);
        end
        wait_idle();
    endtask

    initial
    begin : rx_ready_gen
        int hold_left;
        int cyc;
        hold_left = 0;
        cyc = 0;
        rpt_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_left == 0 && rx_hold_len != 0)
            begin
                hold_left = rx_hold_len;
                rx_hold_len = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rpt_ch.ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RxRandom:   rpt_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
                    RxPeriodic: rpt_ch.ready <= ((cyc % 7) < 4);
                    default:    rpt_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rpt_ch.valid && rpt_ch.ready)
        begin
            bytes_seen++;
            if (pending_bytes.size() == 0)
                report_mismatch("unexpected byte", rpt_ch.out_char, 0);
            else
            begin
                want_byte = pending_bytes.pop_front();
                if (rpt_ch.out_char !== want_byte.ch)
                    report_mismatch("out_char", rpt_ch.out_char, want_byte.ch);
                if (rpt_ch.last_char !== want_byte.last)
                    report_mismatch("last_char", rpt_ch.last_char, want_byte.last);
                if (rpt_ch.pos_invalid !== want_byte.invalid)
                    report_mismatch("pos_invalid", rpt_ch.pos_invalid, want_byte.invalid);
            end
        end
    end

    initial
    begin
        #(12 * 500000);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        pos_ch.valid     <= 1'b0;
        pos_ch.lat_micro <= '0;
        pos_ch.lon_micro <= '0;
        pos_ch.fix_level <= '0;
        sym_table = SymTableRst;
        sym_code  = SymCodeRst;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_symbols();
        test_field_extremes();
        test_symbol_settings();
        test_output_backpressure();
        test_pause_until_empty();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
